// ===== src/buddy_block_allocator_core_assert.svh =====
// Assertion macros for the buddy allocator core.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define BBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("buddy allocator check failed");

// next-cycle implication
`define BBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("buddy allocator check failed");

`endif

// ===== src/bba_pkg.sv =====
// Shared types and constants of the buddy allocator core.
// No dependencies.
package bba_pkg;

    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 5;
    localparam int NEED_W        = 18;
    localparam int POOL_ORDER_RST = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_ORDER = 1'd1;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [16:0] request_bytes;
        logic [15:0] address;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] result_address;
        logic [4:0]  block_order;
    } t_rsp;

    typedef enum logic [3:0] {
        C_NONE, C_LOAD, C_SCAN_RD, C_SCAN_CHK, C_SPLIT, C_FIND_RD, C_FIND_CHK,
        C_TAKEN_RD, C_TAKEN_CHK, C_MERGE_RD, C_MERGE_CHK, C_SET_NOFIT,
        C_SET_BAD, C_SET_FREE_OK, C_EMIT
    } t_cmd;

    typedef struct packed {
        logic scan_end;
        logic scan_stop;
        logic found;
        logic split_more;
        logic find_at;
        logic find_hit;
        logic bad_addr;
        logic taken;
        logic merge_room;
        logic merge_ok;
        logic out_busy;
    } t_stat;

endpackage

// ===== src/bba_ctrl.sv =====
// Sequencer of the buddy allocator core: scan, split, walk and merge steps.
// Depends on bba_pkg and the assertion macro header.
`include "buddy_block_allocator_core_assert.svh"
module bba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_req_type,
    output logic          o_in_ready,
    input  bba_pkg::t_stat i_stat,
    output bba_pkg::t_cmd  o_cmd
);
    import bba_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SCAN  = 10'b0000000010,
        S_SCHK  = 10'b0000000100,
        S_SPLIT = 10'b0000001000,
        S_FTEST = 10'b0000010000,
        S_FCHK  = 10'b0000100000,
        S_TCHK  = 10'b0001000000,
        S_MTEST = 10'b0010000000,
        S_MCHK  = 10'b0100000000,
        S_EMIT  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = C_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = C_LOAD;
                    n_state = (i_req_type == REQ_FREE) ? S_FTEST : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_end || i_stat.scan_stop) begin
                    if (i_stat.found) begin
                        n_state = S_SPLIT;
                    end else begin
                        o_cmd   = C_SET_NOFIT;
                        n_state = S_EMIT;
                    end
                end else begin
                    o_cmd   = C_SCAN_RD;
                    n_state = S_SCHK;
                end
            end
            S_SCHK: begin
                o_cmd   = C_SCAN_CHK;
                n_state = S_SCAN;
            end
            S_SPLIT: begin
                o_cmd = C_SPLIT;
                if (!i_stat.split_more) n_state = S_EMIT;
            end
            S_FTEST: begin
                if (i_stat.bad_addr) begin
                    o_cmd   = C_SET_BAD;
                    n_state = S_EMIT;
                end else if (i_stat.find_at) begin
                    if (i_stat.find_hit) begin
                        o_cmd   = C_TAKEN_RD;
                        n_state = S_TCHK;
                    end else begin
                        o_cmd   = C_SET_BAD;
                        n_state = S_EMIT;
                    end
                end else begin
                    o_cmd   = C_FIND_RD;
                    n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                o_cmd   = C_FIND_CHK;
                n_state = S_FTEST;
            end
            S_TCHK: begin
                if (!i_stat.taken) begin
                    o_cmd   = C_SET_BAD;
                    n_state = S_EMIT;
                end else begin
                    o_cmd   = C_TAKEN_CHK;
                    n_state = S_MTEST;
                end
            end
            S_MTEST: begin
                if (i_stat.merge_room) begin
                    o_cmd   = C_MERGE_RD;
                    n_state = S_MCHK;
                end else begin
                    o_cmd   = C_SET_FREE_OK;
                    n_state = S_EMIT;
                end
            end
            S_MCHK: begin
                if (i_stat.merge_ok) begin
                    o_cmd   = C_MERGE_CHK;
                    n_state = S_MTEST;
                end else begin
                    o_cmd   = C_SET_FREE_OK;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd   = C_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_in_ready = (r_state == S_IDLE);

    `BBA_ASSERT_NXT(a_emit_done, i_clk, i_rst_n, (r_state == S_EMIT) && !i_stat.out_busy, r_state == S_IDLE)
    `BBA_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state != S_IDLE)
    `BBA_ASSERT_IMP(a_split_found, i_clk, i_rst_n, r_state == S_SPLIT, i_stat.found)

endmodule

// ===== src/bba_dp.sv =====
// Datapath of the buddy allocator core: granule table, scan registers, result.
// Depends on bba_pkg; driven by commands from bba_ctrl.
module bba_dp #(
    parameter int MIN_ORDER    = 5,
    parameter int MAX_ORDER    = 16,
    parameter int HEADER_BYTES = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bba_pkg::t_cmd                i_cmd,
    output bba_pkg::t_stat               o_stat,
    input  bba_pkg::t_req                i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output bba_pkg::t_rsp                o_out_data,
    input  logic                         i_cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bba_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import bba_pkg::*;

    localparam int GW    = MAX_ORDER - MIN_ORDER;
    localparam int OW    = $clog2(GW + 1);
    localparam int DEPTH = 1 << GW;
    localparam int CW    = (MAX_ORDER + 2 > NEED_W + 1) ? MAX_ORDER + 2 : NEED_W + 1;
    localparam int RST_POOL = (POOL_ORDER_RST < MIN_ORDER) ? MIN_ORDER :
                              ((POOL_ORDER_RST > MAX_ORDER) ? MAX_ORDER : POOL_ORDER_RST);

    typedef struct packed {
        logic [OW-1:0] order;
        logic          taken;
    } t_ent;

    t_ent mem [DEPTH];
    t_ent r_rd_data;

    t_req            r_req;
    logic [NEED_W-1:0] r_need;
    logic [GW:0]     r_g;
    logic [GW-1:0]   r_pick;
    logic [OW-1:0]   r_rel;
    logic            r_found, r_stop;
    logic [1:0]      r_fit;
    logic [OW-1:0]   r_top;
    t_rsp            r_res, r_out;
    logic            r_out_valid;

    logic [GW-1:0]   rd_addr, wr_addr, bit_rel, bit_relm1, gi;
    t_ent            wr_data;
    logic            wr_en;
    logic [GW:0]     limit, target, step;
    logic [16:0]     start;
    logic [CW-1:0]   sz, sz_rel, need_x, need2_x;
    logic            take, fit_sel;
    logic [4:0]      cfg_clamp;
    logic [OW-1:0]   cfg_top;
    logic [MAX_ORDER:0] res_sum;

    assign gi        = r_g[GW-1:0];
    assign limit     = (GW+1)'(1) << r_top;
    assign step      = (GW+1)'(1) << r_rd_data.order;
    assign bit_rel   = GW'(1) << r_rel;
    assign bit_relm1 = GW'(1) << (r_rel - OW'(1));
    assign start     = {1'b0, r_req.address} - 17'(HEADER_BYTES);
    assign target    = (GW+1)'(start >> MIN_ORDER);
    assign need_x    = CW'(r_need);
    assign need2_x   = CW'(r_need) << 1;
    assign sz        = CW'(1) << (CW'(r_rd_data.order) + CW'(MIN_ORDER));
    assign sz_rel    = CW'(1) << (CW'(r_rel) + CW'(MIN_ORDER));
    assign fit_sel   = (r_fit == FIT_BEST) || (r_fit == FIT_WORST);
    assign res_sum   = {1'b0, r_pick, MIN_ORDER'(0)} + (MAX_ORDER+1)'(HEADER_BYTES);

    always_comb begin
        take = 1'b0;
        if (!r_rd_data.taken && (sz >= need_x)) begin
            if (!r_found)                 take = 1'b1;
            else if (r_fit == FIT_BEST)   take = r_rd_data.order < r_rel;
            else if (r_fit == FIT_WORST)  take = r_rd_data.order > r_rel;
        end
    end

    always_comb begin
        cfg_clamp = i_cfg_wdata;
        if (i_cfg_wdata < 5'(MIN_ORDER))      cfg_clamp = 5'(MIN_ORDER);
        else if (i_cfg_wdata > 5'(MAX_ORDER)) cfg_clamp = 5'(MAX_ORDER);
        cfg_top = OW'(cfg_clamp - 5'(MIN_ORDER));
    end

    always_comb begin
        o_stat.scan_end   = r_g >= limit;
        o_stat.scan_stop  = r_stop;
        o_stat.found      = r_found;
        o_stat.split_more = (r_rel != '0) && (sz_rel >= need2_x);
        o_stat.find_at    = r_g >= target;
        o_stat.find_hit   = r_g == target;
        o_stat.bad_addr   = (r_req.address < 16'(HEADER_BYTES)) ||
                            (start[MIN_ORDER-1:0] != '0) ||
                            (17'(start >> MIN_ORDER) >= 17'(limit));
        o_stat.taken      = r_rd_data.taken;
        o_stat.merge_room = r_rel < r_top;
        o_stat.merge_ok   = (r_rd_data.order == r_rel) && !r_rd_data.taken;
        o_stat.out_busy   = r_out_valid && !i_out_ready;
    end

    always_comb begin
        rd_addr = gi;
        wr_en   = 1'b0;
        wr_addr = gi;
        wr_data = '{order: r_rel, taken: 1'b0};
        case (i_cmd)
            C_SPLIT: begin
                wr_en = 1'b1;
                if (o_stat.split_more) begin
                    wr_addr = r_pick ^ bit_relm1;
                    wr_data = '{order: r_rel - OW'(1), taken: 1'b0};
                end else begin
                    wr_addr = r_pick;
                    wr_data = '{order: r_rel, taken: 1'b1};
                end
            end
            C_TAKEN_CHK: begin
                wr_en   = 1'b1;
                wr_data = '{order: r_rd_data.order, taken: 1'b0};
            end
            C_MERGE_RD: rd_addr = gi ^ bit_rel;
            C_MERGE_CHK: begin
                wr_en   = 1'b1;
                wr_addr = gi & ~bit_rel;
                wr_data = '{order: r_rel + OW'(1), taken: 1'b0};
            end
            default: ;
        endcase
        if (i_cfg_we && (i_cfg_idx == REG_POOL_ORDER)) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = '{order: cfg_top, taken: 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  mem[0] <= '{order: OW'(RST_POOL - MIN_ORDER), taken: 1'b0};
        else if (wr_en) mem[wr_addr] <= wr_data;
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit       <= FIT_FIRST;
            r_top       <= OW'(RST_POOL - MIN_ORDER);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_FIT_MODE)   r_fit <= i_cfg_wdata[1:0];
                if (i_cfg_idx == REG_POOL_ORDER) r_top <= cfg_top;
            end
            if (i_cmd == C_EMIT)   r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            C_LOAD: begin
                r_req   <= i_in_data;
                r_need  <= NEED_W'(i_in_data.request_bytes) + NEED_W'(HEADER_BYTES);
                r_g     <= '0;
                r_found <= 1'b0;
                r_stop  <= 1'b0;
            end
            C_SCAN_CHK: begin
                if (take) begin
                    r_pick  <= gi;
                    r_rel   <= r_rd_data.order;
                    r_found <= 1'b1;
                    r_stop  <= !fit_sel;
                end
                r_g <= r_g + step;
            end
            C_SPLIT: begin
                if (o_stat.split_more) begin
                    r_rel <= r_rel - OW'(1);
                end else begin
                    r_res <= '{status: ST_OK, result_address: 16'(res_sum),
                               block_order: 5'(r_rel) + 5'(MIN_ORDER)};
                end
            end
            C_FIND_CHK:  r_g <= r_g + step;
            C_TAKEN_CHK: r_rel <= r_rd_data.order;
            C_MERGE_CHK: begin
                r_g   <= {1'b0, gi & ~bit_rel};
                r_rel <= r_rel + OW'(1);
            end
            C_SET_NOFIT: r_res <= '{status: ST_NOFIT, result_address: '0, block_order: '0};
            C_SET_BAD:   r_res <= '{status: ST_BAD, result_address: '0, block_order: '0};
            C_SET_FREE_OK: r_res <= '{status: ST_OK, result_address: '0,
                                      block_order: 5'(r_rel) + 5'(MIN_ORDER)};
            C_EMIT:      r_out <= r_res;
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== src/buddy_block_allocator_core.sv =====
// Top level of the buddy allocator core: sequencer plus table datapath.
// Depends on bba_pkg, bba_ctrl and bba_dp.
//
//  channel | signals                               | dir
//  in      | i_in_valid, o_in_ready, i_in_data     | request beat in
//  out     | o_out_valid, i_out_ready, o_out_data  | response beat out
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_wdata      | register write
//
// One request at a time. Allocate: a table read and a check per block start
// visited by the scan, then one table write per split. Free: a read and a check
// per block start walked below the target, a read and a check per merge. Worst
// case is set by the single table read port.
// Reset is synchronous; table entry 0 is set on reset, no clearing pass.
// The response sits in an output register; a stall holds it and the next
// request finishes behind it, waiting only to hand over its response.
module buddy_block_allocator_core #(
    parameter int MIN_ORDER    = 5,
    parameter int MAX_ORDER    = 16,
    parameter int HEADER_BYTES = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  bba_pkg::t_req                i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output bba_pkg::t_rsp                o_out_data,
    input  logic                         i_cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bba_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import bba_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_data.req_type),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bba_dp #(
        .MIN_ORDER    (MIN_ORDER),
        .MAX_ORDER    (MAX_ORDER),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

endmodule
